// ===== src/rthp_pkg.sv =====
package rthp_pkg;

    // widths of the byte offset and of the wider field positions
    localparam int unsigned OffW = 16;
    localparam int unsigned PosW = OffW + 1;

    typedef logic [7:0]      byte_t;
    typedef logic [OffW-1:0] offset_t;
    typedef logic [PosW-1:0] pos_t;

    // fixed offsets within the header, the offset limit and the minimum header length
    localparam offset_t LenLoOffset   = 16'd2;
    localparam offset_t LenHiOffset   = 16'd3;
    localparam offset_t PresentOffset = 16'd4;
    localparam offset_t MaxOffset     = 16'hFFFF;
    localparam offset_t MinHeader     = 16'd8;

    // field sizes and alignments
    localparam pos_t TsftBytes    = 17'd8;
    localparam pos_t ChannelAlign = 17'd2;

    // present bit positions in the first present word; BitExtend is within the last byte of each word
    localparam int unsigned BitTsft    = 0;
    localparam int unsigned BitFlags   = 1;
    localparam int unsigned BitRate    = 2;
    localparam int unsigned BitChannel = 3;
    localparam int unsigned BitExtend  = 7;

endpackage

// ===== src/rthp_byte_if.sv =====
interface rthp_byte_if;
    logic           valid;
    logic           ready;
    rthp_pkg::byte_t data_byte;
    logic           first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// ===== src/rthp_result_if.sv =====
interface rthp_result_if;
    logic              valid;
    logic              ready;
    rthp_pkg::byte_t   rate_value;
    logic              rate_found;
    rthp_pkg::offset_t channel_mhz;
    logic              channel_found;
    rthp_pkg::offset_t header_bytes;
    logic              short_header;

    modport source (
        output valid, output rate_value, output rate_found, output channel_mhz,
        output channel_found, output header_bytes, output short_header, input ready
    );
    modport sink (
        input valid, input rate_value, input rate_found, input channel_mhz,
        input channel_found, input header_bytes, input short_header, output ready
    );
endinterface

// ===== src/radiotap_header_parser_unit.sv =====
// radiotap header parser
// byte_ch carries packet bytes one per transaction; first_byte marks byte 0 of a
// radiotap header. result_ch carries one transaction per header: on its last byte
// with rate and channel (when present and inside the header) and the length, or
// after byte 3 with short_header set when the length is below 8.
// bytes outside a header give no result; a new first_byte drops an unfinished one.
// throughput: one byte per cycle while the result register is not stalled. a byte
// waits in the input register, then the per-byte offset compares update the parse
// state and load the result register, which offers the result on result_ch.
// the single result register decides the rate: while it holds a result that the
// receiver stalls, the input register holds its byte and byte_ch.ready falls
// once that register is full too; no transaction is lost or repeated.
// reset clears all parse state and both valid flags; the block is then idle and
// ignores bytes until the first byte of a header.
module radiotap_header_parser_unit (
    input  logic          clk,
    input  logic          rst_n,
    rthp_byte_if.sink     byte_ch,
    rthp_result_if.source result_ch
);

    // input register
    logic            s1_valid_reg;
    rthp_pkg::byte_t s1_byte_reg;
    logic            s1_first_reg;

    // parse state
    rthp_pkg::offset_t off_reg, off_next;
    rthp_pkg::offset_t len_reg, len_next;
    logic [3:0]        fpb_reg, fpb_next;
    logic              chain_reg, chain_next;
    logic              active_reg, active_next;
    rthp_pkg::byte_t   rate_cap_reg, rate_cap_next;
    rthp_pkg::offset_t chan_cap_reg, chan_cap_next;
    rthp_pkg::pos_t    rate_off_reg, rate_off_next;
    rthp_pkg::pos_t    chan_off_reg, chan_off_next;

    // result register
    logic              out_valid_reg;
    rthp_pkg::byte_t   out_rate_reg, out_rate_next;
    logic              out_rf_reg, out_rf_next;
    rthp_pkg::offset_t out_chan_reg, out_chan_next;
    logic              out_cf_reg, out_cf_next;
    rthp_pkg::offset_t out_len_reg, out_len_next;
    logic              out_short_reg, out_short_next;

    // state as seen by the byte in the input register
    rthp_pkg::offset_t off_eff, len_eff, chan_cap_eff;
    logic [3:0]        fpb_eff;
    logic              chain_eff, active_eff;
    rthp_pkg::byte_t   rate_cap_eff;
    rthp_pkg::pos_t    off_pos;

    // field positions for a chain that ends on this byte
    rthp_pkg::offset_t body_start;
    rthp_pkg::pos_t    pos_body, pos_tsft, pos_rate, pos_after_rate, pos_chan;

    logic adv, take, emit;

    // handshake
    assign adv          = !out_valid_reg || result_ch.ready;
    assign take         = s1_valid_reg && adv;
    assign byte_ch.ready = !s1_valid_reg || adv;

    // a first byte starts from the cleared state
    assign off_eff      = s1_first_reg ? '0 : off_reg;
    assign len_eff      = s1_first_reg ? '0 : len_reg;
    assign fpb_eff      = s1_first_reg ? '0 : fpb_reg;
    assign chain_eff    = s1_first_reg ? 1'b1 : chain_reg;
    assign active_eff   = s1_first_reg | active_reg;
    assign rate_cap_eff = s1_first_reg ? '0 : rate_cap_reg;
    assign chan_cap_eff = s1_first_reg ? '0 : chan_cap_reg;
    assign off_pos      = {1'b0, off_eff};

    // field layout after the present chain, aligned to the header start
    assign body_start     = off_eff + rthp_pkg::offset_t'(1);
    assign pos_body       = {1'b0, body_start};
    assign pos_tsft       = fpb_eff[rthp_pkg::BitTsft]
                          ? (((pos_body + rthp_pkg::TsftBytes - rthp_pkg::pos_t'(1))
                              & ~(rthp_pkg::TsftBytes - rthp_pkg::pos_t'(1)))
                             + rthp_pkg::TsftBytes)
                          : pos_body;
    assign pos_rate       = pos_tsft + rthp_pkg::pos_t'(fpb_eff[rthp_pkg::BitFlags]);
    assign pos_after_rate = pos_rate + rthp_pkg::pos_t'(fpb_eff[rthp_pkg::BitRate]);
    assign pos_chan       = (pos_after_rate + rthp_pkg::ChannelAlign - rthp_pkg::pos_t'(1))
                          & ~(rthp_pkg::ChannelAlign - rthp_pkg::pos_t'(1));

    // per-byte parse step
    always_comb
    begin
        off_next       = off_reg;
        len_next       = len_reg;
        fpb_next       = fpb_reg;
        chain_next     = chain_reg;
        active_next    = active_reg;
        rate_cap_next  = rate_cap_reg;
        chan_cap_next  = chan_cap_reg;
        rate_off_next  = rate_off_reg;
        chan_off_next  = chan_off_reg;
        out_rate_next  = out_rate_reg;
        out_rf_next    = out_rf_reg;
        out_chan_next  = out_chan_reg;
        out_cf_next    = out_cf_reg;
        out_len_next   = out_len_reg;
        out_short_next = out_short_reg;
        emit           = 1'b0;

        if (take)
        begin
            off_next      = off_eff;
            len_next      = len_eff;
            fpb_next      = fpb_eff;
            chain_next    = chain_eff;
            active_next   = active_eff;
            rate_cap_next = rate_cap_eff;
            chan_cap_next = chan_cap_eff;

            if (active_eff)
            begin
                if (off_eff == rthp_pkg::LenLoOffset)
                begin
                    len_next = {8'h00, s1_byte_reg};
                end
                else if (off_eff == rthp_pkg::LenHiOffset)
                begin
                    len_next = {s1_byte_reg, len_eff[7:0]};
                    if ({s1_byte_reg, len_eff[7:0]} < rthp_pkg::MinHeader)
                    begin
                        emit           = 1'b1;
                        out_rate_next  = '0;
                        out_rf_next    = 1'b0;
                        out_chan_next  = '0;
                        out_cf_next    = 1'b0;
                        out_len_next   = {s1_byte_reg, len_eff[7:0]};
                        out_short_next = 1'b1;
                        active_next    = 1'b0;
                    end
                end
                else if (off_eff >= rthp_pkg::PresentOffset && chain_eff)
                begin
                    // walk the present words
                    if (off_eff == rthp_pkg::PresentOffset)
                    begin
                        fpb_next = s1_byte_reg[3:0];
                    end
                    if (off_eff[1:0] == 2'b11 && !s1_byte_reg[rthp_pkg::BitExtend])
                    begin
                        chain_next    = 1'b0;
                        rate_off_next = pos_rate;
                        chan_off_next = pos_chan;
                    end
                end
                else if (off_eff >= rthp_pkg::PresentOffset)
                begin
                    // capture the fields at their offsets
                    if (fpb_eff[rthp_pkg::BitRate] && off_pos == rate_off_reg)
                    begin
                        rate_cap_next = s1_byte_reg;
                    end
                    if (fpb_eff[rthp_pkg::BitChannel])
                    begin
                        if (off_pos == chan_off_reg)
                        begin
                            chan_cap_next = {chan_cap_eff[15:8], s1_byte_reg};
                        end
                        else if (off_pos == chan_off_reg + rthp_pkg::pos_t'(1))
                        begin
                            chan_cap_next = {s1_byte_reg, chan_cap_eff[7:0]};
                        end
                    end
                end

                // last header byte
                if (!emit && off_eff >= rthp_pkg::LenHiOffset
                    && off_pos + rthp_pkg::pos_t'(1) == {1'b0, len_next})
                begin
                    emit           = 1'b1;
                    out_rf_next    = !chain_eff && off_eff >= rthp_pkg::PresentOffset
                                   && fpb_eff[rthp_pkg::BitRate] && rate_off_reg <= off_pos;
                    out_cf_next    = !chain_eff && off_eff >= rthp_pkg::PresentOffset
                                   && fpb_eff[rthp_pkg::BitChannel]
                                   && chan_off_reg + rthp_pkg::pos_t'(1) <= off_pos;
                    out_rate_next  = out_rf_next ? rate_cap_next : '0;
                    out_chan_next  = out_cf_next ? chan_cap_next : '0;
                    out_len_next   = len_next;
                    out_short_next = 1'b0;
                    active_next    = 1'b0;
                end

                // advance the offset, saturating
                if (!emit && off_eff != rthp_pkg::MaxOffset)
                begin
                    off_next = off_eff + rthp_pkg::offset_t'(1);
                end
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            s1_valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
        begin
            s1_byte_reg  <= byte_ch.data_byte;
            s1_first_reg <= byte_ch.first_byte;
        end
    end

    // parse state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg       <= '0;
            len_reg       <= '0;
            fpb_reg       <= '0;
            chain_reg     <= 1'b0;
            active_reg    <= 1'b0;
            rate_cap_reg  <= '0;
            chan_cap_reg  <= '0;
            rate_off_reg  <= '0;
            chan_off_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            off_reg       <= off_next;
            len_reg       <= len_next;
            fpb_reg       <= fpb_next;
            chain_reg     <= chain_next;
            active_reg    <= active_next;
            rate_cap_reg  <= rate_cap_next;
            chan_cap_reg  <= chan_cap_next;
            rate_off_reg  <= rate_off_next;
            chan_off_reg  <= chan_off_next;
            if (adv)
            begin
                out_valid_reg <= take && emit;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_rate_reg  <= out_rate_next;
        out_rf_reg    <= out_rf_next;
        out_chan_reg  <= out_chan_next;
        out_cf_reg    <= out_cf_next;
        out_len_reg   <= out_len_next;
        out_short_reg <= out_short_next;
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.rate_value    = out_rate_reg;
    assign result_ch.rate_found    = out_rf_reg;
    assign result_ch.channel_mhz   = out_chan_reg;
    assign result_ch.channel_found = out_cf_reg;
    assign result_ch.header_bytes  = out_len_reg;
    assign result_ch.short_header  = out_short_reg;

    // a short header result never reports fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_short_reg |-> !out_rf_reg && !out_cf_reg)
        else $error("short header result reports a field");

    // a full result always carries a length of at least the minimum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_short_reg |-> out_len_reg >= rthp_pkg::MinHeader)
        else $error("full result with a short length");

    // a result ends the header
    assert property (@(posedge clk) disable iff (!rst_n)
        take && emit |=> !active_reg)
        else $error("header still active after its result");

    // the chain only ends after the first present word
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !chain_reg |-> off_reg >= rthp_pkg::MinHeader)
        else $error("present chain ended too early");

    // a new result needs a byte in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a byte");

endmodule
